FILE: rtl/mspf_pkg.sv
// mspf_pkg: shared types, constants and the sigmoid table builder for the
// sigmoid MLP forward pass. No dependencies.
package mspf_pkg;

	// Default network shape
	localparam int DEF_N_INPUTS        = 2;
	localparam int DEF_N_HIDDEN        = 2;
	localparam int DEF_N_OUTPUTS       = 1;
	localparam int DEF_SIGMOID_ENTRIES = 256;

	// Fixed field and datapath widths
	localparam int IDX_W   = 4;   // neuron index fields
	localparam int VAL_W   = 16;  // Q4.12 values
	localparam int ACT_W   = 13;  // Q0.12 activations, 4096 = one
	localparam int WADDR_W = 8;   // linear weight address, up to 16x16
	localparam int X_W     = 17;  // multiplier operand holding a feature or activation
	localparam int PROD_W  = VAL_W + X_W;
	localparam int ACC_W   = PROD_W + IDX_W;  // room for 16 products
	localparam int FRAC_W  = 12;

	// Sigmoid table
	localparam int          SIG_SPAN     = 256;
	localparam int          SIG_MID      = 128;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;  // exp(-1/16) in Q32

	// Operation codes
	localparam logic [1:0] OP_HID_WEIGHT = 2'd0;
	localparam logic [1:0] OP_OUT_WEIGHT = 2'd1;
	localparam logic [1:0] OP_FEATURE    = 2'd2;

	// Layer select
	localparam logic LAYER_HIDDEN = 1'b0;
	localparam logic LAYER_OUTPUT = 1'b1;

	typedef struct packed {
		logic [1:0]              operation;
		logic [IDX_W-1:0]        weight_dest;
		logic [IDX_W-1:0]        weight_source;
		logic [IDX_W-1:0]        feature_index;
		logic signed [VAL_W-1:0] value;
		logic                    last_feature;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] output_index;
		logic [ACT_W-1:0] activation;
		logic             last_output;
	} result_t;

	// One multiply-accumulate step issued by the controller
	typedef struct packed {
		logic               valid;
		logic               layer;
		logic               first;
		logic               last;
		logic [IDX_W-1:0]   dest;
		logic [IDX_W-1:0]   src;
		logic [WADDR_W-1:0] waddr;
	} cmd_t;

	// Step flags carried down the datapath pipe
	typedef struct packed {
		logic             valid;
		logic             layer;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] dest;
	} stage_t;

	typedef struct packed {
		logic idle;
	} dp_status_t;

	typedef logic [SIG_SPAN-1:0][ACT_W-1:0] sig_rom_t;

	function automatic int addr_w(input int n);
		return (n <= 1) ? 1 : $clog2(n);
	endfunction

	// Rounded quotient (2*num + den) / (2*den) by shift and subtract.
	// Elaboration only.
	function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		logic [64:0] r;
		n = (num << 1) + den;
		d = den << 1;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Table entry i = round(4096 / (1 + exp(-(i - 128) / 16))), built with
	// the exp(-k/16) walk in Q32 so both halves round the same way.
	function automatic sig_rom_t build_sigmoid();
		sig_rom_t    rom;
		logic [63:0] t;
		logic [63:0] den;
		logic [63:0] q;
		rom = '0;
		t   = 64'd1 << 32;
		for (int k = 0; k <= SIG_MID; k++) begin
			den = (64'd1 << 32) + t;
			if (SIG_MID + k < SIG_SPAN) begin
				q = div_round(64'd4096 << 32, den);
				rom[SIG_MID + k] = q[ACT_W-1:0];
			end
			q = div_round(64'd4096 * t, den);
			rom[SIG_MID - k] = q[ACT_W-1:0];
			t = (t * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

endpackage

FILE: rtl/mspf_ctrl.sv
// mspf_ctrl: sequencer for the forward pass. Accepts words, walks the
// hidden then output weights one MAC step per cycle. Depends on mspf_pkg.
module mspf_ctrl #(
	parameter int N_INPUTS  = mspf_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN  = mspf_pkg::DEF_N_HIDDEN,
	parameter int N_OUTPUTS = mspf_pkg::DEF_N_OUTPUTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  mspf_pkg::item_t        item,
	input  mspf_pkg::dp_status_t   status,
	output logic                   busy,
	output logic                   wr_en,
	output mspf_pkg::cmd_t         cmd
);
	import mspf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HID,
		S_HID_DRAIN,
		S_OUT,
		S_OUT_DRAIN
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	cmd_t   adv;
	logic [IDX_W-1:0] src_lim;
	logic [IDX_W-1:0] dst_lim;
	logic             layer_done;

	assign busy  = (state_q != S_IDLE);
	assign wr_en = start && (state_q == S_IDLE);
	assign cmd   = cmd_q;

	// Next step within the current layer
	always_comb begin
		src_lim = (state_q == S_OUT) ? IDX_W'(N_HIDDEN - 1) : IDX_W'(N_INPUTS - 1);
		dst_lim = (state_q == S_OUT) ? IDX_W'(N_OUTPUTS - 1) : IDX_W'(N_HIDDEN - 1);
		layer_done = cmd_q.last && (cmd_q.dest == dst_lim);
		adv       = cmd_q;
		adv.src   = cmd_q.last ? '0 : cmd_q.src + 1'b1;
		adv.dest  = cmd_q.last ? cmd_q.dest + 1'b1 : cmd_q.dest;
		adv.waddr = cmd_q.waddr + 1'b1;
		adv.first = (adv.src == '0);
		adv.last  = (adv.src == src_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (wr_en && item.operation == OP_FEATURE && item.last_feature) begin
						state_q <= S_HID;
						cmd_q   <= '{valid: 1'b1, layer: LAYER_HIDDEN, first: 1'b1,
							last: (N_INPUTS == 1), default: '0};
					end
				end
				S_HID: begin
					if (layer_done) begin
						state_q     <= S_HID_DRAIN;
						cmd_q.valid <= 1'b0;
					end else begin
						cmd_q <= adv;
					end
				end
				S_HID_DRAIN: begin
					// wait until the last hidden activation is written back
					if (status.idle) begin
						state_q <= S_OUT;
						cmd_q   <= '{valid: 1'b1, layer: LAYER_OUTPUT, first: 1'b1,
							last: (N_HIDDEN == 1), default: '0};
					end
				end
				S_OUT: begin
					if (layer_done) begin
						state_q     <= S_OUT_DRAIN;
						cmd_q.valid <= 1'b0;
					end else begin
						cmd_q <= adv;
					end
				end
				S_OUT_DRAIN: begin
					if (status.idle) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/mspf_dp.sv
// mspf_dp: weight/feature/activation memories, shared MAC pipe and the
// sigmoid lookup. Depends on mspf_pkg.
module mspf_dp #(
	parameter int N_INPUTS        = mspf_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN        = mspf_pkg::DEF_N_HIDDEN,
	parameter int N_OUTPUTS       = mspf_pkg::DEF_N_OUTPUTS,
	parameter int SIGMOID_ENTRIES = mspf_pkg::DEF_SIGMOID_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mspf_pkg::item_t        item,
	input  logic                   wr_en,
	input  mspf_pkg::cmd_t         cmd,
	output mspf_pkg::dp_status_t   status,
	output mspf_pkg::result_t      result,
	output logic                   strobe
);
	import mspf_pkg::*;

	localparam int HW_DEPTH = N_HIDDEN * N_INPUTS;
	localparam int OW_DEPTH = N_OUTPUTS * N_HIDDEN;
	localparam int HW_AW    = addr_w(HW_DEPTH);
	localparam int OW_AW    = addr_w(OW_DEPTH);
	localparam int IN_AW    = addr_w(N_INPUTS);
	localparam int HA_AW    = addr_w(N_HIDDEN);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
	localparam logic signed [10:0] IDX_LO = 11'(-(SIGMOID_ENTRIES / 2));
	localparam logic signed [10:0] IDX_HI = 11'(SIGMOID_ENTRIES / 2 - 1);
	localparam logic signed [10:0] IDX_MID = 11'(SIG_MID);
	localparam logic signed [10:0] IDX_TOP = 11'(SIG_SPAN - 1);
	localparam sig_rom_t SIG_ROM = build_sigmoid();

	// memories
	logic signed [VAL_W-1:0] hw_mem [HW_DEPTH];
	logic signed [VAL_W-1:0] ow_mem [OW_DEPTH];
	logic signed [VAL_W-1:0] ft_mem [N_INPUTS];
	logic        [ACT_W-1:0] ha_mem [N_HIDDEN];

	logic signed [VAL_W-1:0] hw_rd_s1;
	logic signed [VAL_W-1:0] ow_rd_s1;
	logic signed [VAL_W-1:0] ft_rd_s1;
	logic        [ACT_W-1:0] ha_rd_s1;

	stage_t st_s1;
	stage_t st_s2;
	stage_t st_s3;

	logic signed [VAL_W-1:0]  w_sel;
	logic signed [X_W-1:0]    x_sel;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;

	logic [WADDR_W-1:0] hw_waddr;
	logic [WADDR_W-1:0] ow_waddr;
	logic               hw_we;
	logic               ow_we;
	logic               ft_we;
	logic               ha_we;

	logic signed [ACC_W-1:0] acc_sh;
	logic signed [VAL_W-1:0] sum16;
	logic signed [10:0]      idx_raw;
	logic signed [10:0]      idx_clip;
	logic signed [10:0]      idx_mid;
	logic signed [10:0]      idx_rom;
	logic [7:0]              rom_idx;
	logic [ACT_W-1:0]        act;

	result_t result_q;
	logic    strobe_q;

	// word writes, out-of-range indexes dropped
	assign hw_waddr = WADDR_W'(item.weight_dest) * WADDR_W'(N_INPUTS)
		+ WADDR_W'(item.weight_source);
	assign ow_waddr = WADDR_W'(item.weight_dest) * WADDR_W'(N_HIDDEN)
		+ WADDR_W'(item.weight_source);
	assign hw_we = wr_en && item.operation == OP_HID_WEIGHT
		&& {1'b0, item.weight_dest} < 5'(N_HIDDEN)
		&& {1'b0, item.weight_source} < 5'(N_INPUTS);
	assign ow_we = wr_en && item.operation == OP_OUT_WEIGHT
		&& {1'b0, item.weight_dest} < 5'(N_OUTPUTS)
		&& {1'b0, item.weight_source} < 5'(N_HIDDEN);
	assign ft_we = wr_en && item.operation == OP_FEATURE
		&& {1'b0, item.feature_index} < 5'(N_INPUTS);

	always_ff @(posedge clk) begin
		if (hw_we) begin
			hw_mem[hw_waddr[HW_AW-1:0]] <= item.value;
		end
		hw_rd_s1 <= hw_mem[cmd.waddr[HW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ow_we) begin
			ow_mem[ow_waddr[OW_AW-1:0]] <= item.value;
		end
		ow_rd_s1 <= ow_mem[cmd.waddr[OW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ft_we) begin
			ft_mem[item.feature_index[IN_AW-1:0]] <= item.value;
		end
		ft_rd_s1 <= ft_mem[cmd.src[IN_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ha_we) begin
			ha_mem[st_s3.dest[HA_AW-1:0]] <= act;
		end
		ha_rd_s1 <= ha_mem[cmd.src[HA_AW-1:0]];
	end

	// operand select for the shared multiplier
	always_comb begin
		if (st_s1.layer == LAYER_OUTPUT) begin
			w_sel = ow_rd_s1;
			x_sel = signed'({{(X_W - ACT_W){1'b0}}, ha_rd_s1});
		end else begin
			w_sel = hw_rd_s1;
			x_sel = X_W'(ft_rd_s1);
		end
	end

	// pipe: s1 read, s2 multiply, s3 accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			st_s3 <= '0;
		end else begin
			st_s1 <= '{valid: cmd.valid, layer: cmd.layer, first: cmd.first,
				last: cmd.last, dest: cmd.dest};
			st_s2 <= st_s1;
			st_s3 <= st_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_sel * x_sel;
		if (st_s2.valid) begin
			acc_s3 <= st_s2.first ? ACC_W'(prod_s2) : acc_s3 + ACC_W'(prod_s2);
		end
	end

	assign status.idle = !(st_s1.valid || st_s2.valid || st_s3.valid);

	// neuron: floor shift, saturate to Q4.12, table index with end clamps
	always_comb begin
		acc_sh = acc_s3 >>> FRAC_W;
		priority if (acc_sh > SAT_HI) begin
			sum16 = 16'sh7FFF;
		end else if (acc_sh < SAT_LO) begin
			sum16 = -16'sh8000;
		end else begin
			sum16 = acc_sh[VAL_W-1:0];
		end
		idx_raw = 11'(signed'(sum16[15:8]));
		priority if (idx_raw < IDX_LO) begin
			idx_clip = IDX_LO;
		end else if (idx_raw > IDX_HI) begin
			idx_clip = IDX_HI;
		end else begin
			idx_clip = idx_raw;
		end
		idx_mid = idx_clip + IDX_MID;
		priority if (idx_mid < 11'sd0) begin
			idx_rom = 11'sd0;
		end else if (idx_mid > IDX_TOP) begin
			idx_rom = IDX_TOP;
		end else begin
			idx_rom = idx_mid;
		end
		rom_idx = idx_rom[7:0];
		act     = SIG_ROM[rom_idx];
	end

	assign ha_we = st_s3.valid && st_s3.last && st_s3.layer == LAYER_HIDDEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= st_s3.valid && st_s3.last && st_s3.layer == LAYER_OUTPUT;
		end
	end

	always_ff @(posedge clk) begin
		if (st_s3.valid && st_s3.last && st_s3.layer == LAYER_OUTPUT) begin
			result_q.output_index <= st_s3.dest;
			result_q.activation   <= act;
			result_q.last_output  <= (st_s3.dest == IDX_W'(N_OUTPUTS - 1));
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

FILE: rtl/mlp_sigmoid_forward_pass.sv
// Sigmoid MLP forward pass: one hidden layer, no bias, Q4.12 in, Q0.12 out.
// Weight and feature words are taken only while the block is idle. A feature
// word marked last starts an evaluation on one shared MAC: busy stays high
// until the output layer has drained, and no word is taken meanwhile. The
// receiver cannot stall; each result is shown for one cycle with strobe.
// Reset (arst_n low, asynchronous) idles the sequencer; memories keep no reset.
module mlp_sigmoid_forward_pass #(
	parameter int N_INPUTS        = mspf_pkg::DEF_N_INPUTS,
	parameter int N_HIDDEN        = mspf_pkg::DEF_N_HIDDEN,
	parameter int N_OUTPUTS       = mspf_pkg::DEF_N_OUTPUTS,
	parameter int SIGMOID_ENTRIES = mspf_pkg::DEF_SIGMOID_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mspf_pkg::item_t   item,
	output logic              strobe,
	output mspf_pkg::result_t result
);
	import mspf_pkg::*;

	// Controller <-> datapath:
	//   wr_en  - word accepted this edge; datapath stores weight or feature.
	//   cmd    - one MAC step per cycle: layer, neuron, source, weight address.
	//   status - MAC pipe empty; controller waits on it between layers so the
	//            output layer never reads a stale hidden activation.
	logic       wr_en;
	cmd_t       cmd;
	dp_status_t status;

	mspf_ctrl #(
		.N_INPUTS (N_INPUTS),
		.N_HIDDEN (N_HIDDEN),
		.N_OUTPUTS(N_OUTPUTS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.status(status),
		.busy  (busy),
		.wr_en (wr_en),
		.cmd   (cmd)
	);

	// Datapath: memory read, 16x17 multiply, 37-bit accumulate, then
	// shift/saturate and a 256-entry sigmoid table lookup. Hidden results
	// go back to the activation memory, output results to the result register.
	mspf_dp #(
		.N_INPUTS       (N_INPUTS),
		.N_HIDDEN       (N_HIDDEN),
		.N_OUTPUTS      (N_OUTPUTS),
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.wr_en (wr_en),
		.cmd   (cmd),
		.status(status),
		.result(result),
		.strobe(strobe)
	);

endmodule

FILE: dv/tb_mlp_sigmoid_forward_pass.sv
// Self-checking testbench for mlp_sigmoid_forward_pass: random weight and feature
// words in, every strobed output activation checked against an in-bench predictor.
// Depends on mspf_pkg and the mlp_sigmoid_forward_pass RTL.
module tb_mlp_sigmoid_forward_pass;
	import mspf_pkg::*;

	// Network shape: the block is built with its default parameters
	localparam int NI    = DEF_N_INPUTS;
	localparam int NH    = DEF_N_HIDDEN;
	localparam int NO    = DEF_N_OUTPUTS;
	localparam int SIG_N = DEF_SIGMOID_ENTRIES;

	// Sigmoid curve: 256 points, slope step exp(-1/16) in Q32
	localparam int              CURVE_N       = 256;
	localparam int              CURVE_MID     = 128;
	localparam longint unsigned EXP_DECAY_Q32 = 64'd4034748382;

	// The block has no code for operation 3; it must ignore such words
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 260;
	localparam int QUIET_LIMIT  = 1000;  // hang limit: longer than any busy window or driver idle gap
	localparam int TAIL_CYCLES  = 40;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	mlp_sigmoid_forward_pass u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: its own copy of weights, features and activations
	// ------------------------------------------------------------------
	logic signed [VAL_W-1:0] hid_w    [NH*NI];
	logic signed [VAL_W-1:0] out_w    [NO*NH];
	logic signed [VAL_W-1:0] feat_buf [NI];
	logic [ACT_W-1:0]        hid_act  [NH];
	logic [ACT_W-1:0]        sig_curve[CURVE_N];

	result_t expected_outputs[$];  // activations still to be strobed
	item_t   pending_words[$];     // stimulus not yet presented

	int   words_queued   = 0;
	int   words_accepted = 0;
	int   mismatches     = 0;
	int   quiet_cycles   = 0;
	int   gap_left       = 0;
	int   burst_left     = 0;
	logic word_taken     = 1'b0;
	result_t oldest;

	// round(num / den), half up
	function automatic logic [ACT_W-1:0] rounded_quot(longint unsigned num,
			longint unsigned den);
		return ACT_W'((2 * num + den) / (2 * den));
	endfunction

	// Walk exp(-k/16) outward from the midpoint; both halves share the same t
	// so the curve stays symmetric around 2048.
	function automatic void build_sig_curve();
		longint unsigned t;
		longint unsigned den;
		t = 64'd1 << 32;
		for (int k = 0; k <= CURVE_MID; k++) begin
			den = (64'd1 << 32) + t;
			if (CURVE_MID + k < CURVE_N)
				sig_curve[CURVE_MID + k] = rounded_quot(64'd4096 << 32, den);
			sig_curve[CURVE_MID - k] = rounded_quot(64'd4096 * t, den);
			t = (t * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
		end
	endfunction

	// Q.24 sum -> floor to Q4.12, saturate, index the curve by the top byte
	function automatic logic [ACT_W-1:0] squash(longint acc);
		longint s;
		longint k;
		s = acc >>> FRAC_W;
		if (s > 32767)  s = 32767;
		if (s < -32768) s = -32768;
		k = (s >>> 8) + SIG_N / 2;
		if (k < 0)         k = 0;
		if (k > SIG_N - 1) k = SIG_N - 1;
		k = k - SIG_N / 2 + CURVE_MID;
		if (k < 0)           k = 0;
		if (k > CURVE_N - 1) k = CURVE_N - 1;
		return sig_curve[k];
	endfunction

	// Update the predictor with one accepted word; a last feature runs the
	// whole forward pass and queues one activation per output neuron.
	function automatic void apply_word(item_t w);
		longint  acc;
		result_t r;
		case (w.operation)
			OP_HID_WEIGHT: begin
				if (w.weight_dest < NH && w.weight_source < NI)
					hid_w[w.weight_dest * NI + w.weight_source] = w.value;
			end
			OP_OUT_WEIGHT: begin
				if (w.weight_dest < NO && w.weight_source < NH)
					out_w[w.weight_dest * NH + w.weight_source] = w.value;
			end
			OP_FEATURE: begin
				if (w.feature_index < NI)
					feat_buf[w.feature_index] = w.value;
				if (w.last_feature) begin
					for (int h = 0; h < NH; h++) begin
						acc = 0;
						for (int i = 0; i < NI; i++)
							acc += longint'(feat_buf[i]) * longint'(hid_w[h * NI + i]);
						hid_act[h] = squash(acc);
					end
					for (int j = 0; j < NO; j++) begin
						acc = 0;
						for (int h = 0; h < NH; h++)
							acc += longint'(hid_act[h]) * longint'(out_w[j * NH + h]);
						r.output_index = IDX_W'(j);
						r.activation   = squash(acc);
						r.last_output  = (j == NO - 1);
						expected_outputs = {expected_outputs, r};
					end
				end
			end
			default: ;  // unused operation: no effect
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void queue_word(logic [1:0] op, logic [IDX_W-1:0] dest,
			logic [IDX_W-1:0] src, logic [IDX_W-1:0] fidx,
			logic signed [VAL_W-1:0] v, logic last);
		item_t w;
		w.operation     = op;
		w.weight_dest   = dest;
		w.weight_source = src;
		w.feature_index = fidx;
		w.value         = v;
		w.last_feature  = last;
		pending_words = {pending_words, w};
		words_queued++;
	endfunction

	// Mix of full-range, small, mid-range and extreme Q4.12 values
	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom);
			1: return VAL_W'($urandom_range(0, 8191) - 4096);
			2: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: return VAL_W'($urandom_range(0, 32767) - 16384);
		endcase
	endfunction

	// Don't-care fields and idle bus contents
	function automatic logic [IDX_W-1:0] any_idx();
		return IDX_W'($urandom);
	endfunction

	function automatic item_t junk_word();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(item_t)-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents words at the falling edge, holds each one until it
	// is taken, then idles for a drawn number of cycles.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else if (start && !word_taken) begin
			// block is busy: keep the word on the bus
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
			item  <= junk_word();
		end else if (pending_words.size() != 0) begin
			item  <= pending_words[0];
			pending_words.delete(0);
			start <= 1'b1;
			// mostly idle gaps between words, with occasional back-to-back bursts
			if (burst_left > 0) begin
				burst_left--;
				gap_left = 0;
			end else begin
				gap_left = $urandom_range(0, 7);
				if ($urandom_range(0, 39) == 0)
					burst_left = $urandom_range(10, 40);
			end
		end else begin
			start <= 1'b0;
			item  <= junk_word();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: takes words into the predictor, checks each strobed result
	// against the oldest expectation, and watches for a hang.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			word_taken = 1'b0;
		end else begin
			word_taken = start && !busy;
			if (word_taken) begin
				apply_word(item);
				words_accepted++;
			end
			if (strobe) begin
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual idx %0d act %0d last %0b",
						$time, result.output_index, result.activation, result.last_output);
					mismatches++;
				end else begin
					oldest = expected_outputs[0];
					expected_outputs.delete(0);
					if (result.output_index !== oldest.output_index) begin
						$display("%0t: output_index mismatch: expected %0d, actual %0d",
							$time, oldest.output_index, result.output_index);
						mismatches++;
					end
					if (result.activation !== oldest.activation) begin
						$display("%0t: activation mismatch: expected %0d, actual %0d",
							$time, oldest.activation, result.activation);
						mismatches++;
					end
					if (result.last_output !== oldest.last_output) begin
						$display("%0t: last_output mismatch: expected %0b, actual %0b",
							$time, oldest.last_output, result.last_output);
						mismatches++;
					end
				end
			end
			if (word_taken || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_mlp_sigmoid_forward_pass failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int pick;
		int reverse;
		int fi;
		int nw;
		int random_count;

		build_sig_curve();

		// Directed: load every weight and feature before the first evaluation,
		// using the value extremes so the sums saturate both ways.
		queue_word(OP_HID_WEIGHT, 0, 0, any_idx(), 16'sh7FFF, 1'b0);
		queue_word(OP_HID_WEIGHT, 0, 1, any_idx(), 16'sh7FFF, 1'b1);  // last ignored
		queue_word(OP_HID_WEIGHT, 1, 0, any_idx(), 16'sh8000, 1'b0);
		queue_word(OP_HID_WEIGHT, 1, 1, any_idx(), 16'sh8000, 1'b0);
		queue_word(OP_OUT_WEIGHT, 0, 0, any_idx(), 16'sh7FFF, 1'b1);  // last ignored
		queue_word(OP_OUT_WEIGHT, 0, 1, any_idx(), 16'sh8000, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 0, 16'sh7FFF, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 1, 16'sh7FFF, 1'b1);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 0, 16'sh8000, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 1, 16'sh8000, 1'b1);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 0, 16'sh0000, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 1, 16'sh0000, 1'b1);
		// out-of-range writes must leave the weights alone
		queue_word(OP_HID_WEIGHT, 15, 15, any_idx(), 16'sh1234, 1'b0);
		queue_word(OP_HID_WEIGHT, 0, 2, any_idx(), 16'sh1234, 1'b0);
		queue_word(OP_HID_WEIGHT, 2, 0, any_idx(), 16'sh1234, 1'b0);
		queue_word(OP_OUT_WEIGHT, 1, 0, any_idx(), 16'sh1234, 1'b0);
		queue_word(OP_OUT_WEIGHT, 0, 15, any_idx(), 16'sh1234, 1'b0);
		// unused operation, even with last set, does nothing
		queue_word(OP_UNUSED, 15, 15, 15, 16'shFFFF, 1'b1);
		// out-of-range feature: not stored, but its last mark still evaluates
		queue_word(OP_FEATURE, any_idx(), any_idx(), 5, 16'sh4000, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 15, 16'sh4000, 1'b1);
		// moderate weights so the output lands mid-curve
		queue_word(OP_HID_WEIGHT, 0, 0, any_idx(), 16'sh1000, 1'b0);
		queue_word(OP_OUT_WEIGHT, 0, 1, any_idx(), 16'shF000, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 0, 16'sh0800, 1'b0);
		queue_word(OP_FEATURE, any_idx(), any_idx(), 1, 16'shF800, 1'b1);

		// Random: mostly complete feature vectors, some weight updates,
		// plus noise words that the block should ignore.
		random_count = 0;
		while (random_count < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				reverse = $urandom_range(0, 1);
				for (int i = 0; i < NI; i++) begin
					fi = reverse ? NI - 1 - i : i;
					queue_word(OP_FEATURE, any_idx(), any_idx(), IDX_W'(fi), rand_value(),
						i == NI - 1);
					random_count++;
				end
			end else if (pick < 8) begin
				nw = $urandom_range(1, 3);
				for (int i = 0; i < nw; i++) begin
					if ($urandom_range(0, 1))
						queue_word(OP_HID_WEIGHT, IDX_W'($urandom_range(0, NH - 1)),
							IDX_W'($urandom_range(0, NI - 1)), any_idx(), rand_value(),
							1'($urandom));
					else
						queue_word(OP_OUT_WEIGHT, IDX_W'($urandom_range(0, NO - 1)),
							IDX_W'($urandom_range(0, NH - 1)), any_idx(), rand_value(),
							1'($urandom));
					random_count++;
				end
			end else if (pick == 8) begin
				// ignored words: not counted
				case ($urandom_range(0, 3))
					0: queue_word(OP_UNUSED, any_idx(), any_idx(), any_idx(), rand_value(),
						1'($urandom));
					1: queue_word(OP_HID_WEIGHT, IDX_W'($urandom_range(NH, 15)), any_idx(),
						any_idx(), rand_value(), 1'($urandom));
					2: queue_word(OP_OUT_WEIGHT, IDX_W'($urandom_range(NO, 15)), any_idx(),
						any_idx(), rand_value(), 1'($urandom));
					default: queue_word(OP_FEATURE, any_idx(), any_idx(),
						IDX_W'($urandom_range(NI, 15)), rand_value(), 1'b0);
				endcase
			end else begin
				queue_word(OP_FEATURE, any_idx(), any_idx(), IDX_W'($urandom_range(NI, 15)),
					rand_value(), 1'b1);
				random_count++;
			end
		end

		// Reset: held low from the start, released once at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all words taken, all activations seen, then a quiet tail
		// long enough to catch a stray strobe from the last evaluation.
		while (words_accepted < words_queued) @(negedge clk);
		while (expected_outputs.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("tb_mlp_sigmoid_forward_pass passed");
		else
			$display("tb_mlp_sigmoid_forward_pass failed");
		$finish;
	end

endmodule
